// File: rtl/framewise_dc_offset_remover_defines.svh
// ---------------------------------------------------------------------------
// framewise_dc_offset_remover_defines: assertion macros
// Concurrent check wrappers; all of them compile away under ASSERT_OFF.
// ---------------------------------------------------------------------------
`ifndef FRAMEWISE_DC_OFFSET_REMOVER_DEFINES_SVH
`define FRAMEWISE_DC_OFFSET_REMOVER_DEFINES_SVH

`ifndef ASSERT_OFF
// same-cycle implication
`define FDCR_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("fdcr assertion failed");
// next-cycle implication
`define FDCR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("fdcr assertion failed");
`else
`define FDCR_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define FDCR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// File: rtl/fdcr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// fdcr_pkg: shared constants and helpers
// Field widths, register codes and reset values, saturation functions.
// ---------------------------------------------------------------------------
package fdcr_pkg;

	// payload widths
	localparam int CH_W       = 3;
	localparam int SMP_W      = 16;
	localparam int CH_EXT_W   = 7;   // channel compare width, covers channel numbers 0..127

	// configuration
	localparam int FL_W       = 13;
	localparam int INV_W      = 24;
	localparam int RATE_W     = 16;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 24;

	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_LENGTH     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_INV_FRAME_LENGTH = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_REMOVAL_RATE     = 2'd2;

	localparam logic [FL_W-1:0]   FL_RESET   = 13'd256;
	localparam logic [INV_W-1:0]  INV_RESET  = 24'd65536;
	localparam logic [RATE_W-1:0] RATE_RESET = 16'd655;

	// state word widths (Q16.24 in 40 bits)
	localparam int Q_W   = 40;
	localparam int SUM_W = 29;
	localparam int ACC_W = 66;   // headroom for adds around the product

	// shared multiplier: signed 41 x unsigned 24, done as two 25x25 halves
	localparam int MUL_A_W  = 41;
	localparam int MUL_B_W  = 24;
	localparam int MUL_LO_W = 24;
	localparam int MUL_HI_W = 17;
	localparam int PROD_W   = 65;

	localparam int CHANNELS_DEF  = 8;
	localparam int MAX_FRAME_DEF = 4096;

	localparam logic signed [Q_W-1:0] Q_MAX = {1'b0, {(Q_W-1){1'b1}}};
	localparam logic signed [Q_W-1:0] Q_MIN = {1'b1, {(Q_W-1){1'b0}}};

	function automatic logic signed [Q_W-1:0] sat40(input logic signed [ACC_W-1:0] v);
		logic signed [ACC_W-1:0] hi;
		logic signed [ACC_W-1:0] lo;
		hi = ACC_W'(Q_MAX);
		lo = ACC_W'(Q_MIN);
		if (v > hi)
			return Q_MAX;
		else if (v < lo)
			return Q_MIN;
		else
			return v[Q_W-1:0];
	endfunction

	function automatic logic signed [SMP_W-1:0] sat16(input logic signed [17:0] v);
		if (v > 18'sd32767)
			return 16'sh7fff;
		else if (v < -18'sd32768)
			return 16'sh8000;
		else
			return v[SMP_W-1:0];
	endfunction

endpackage

`default_nettype wire

// File: rtl/fdcr_ifs.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// fdcr_ifs: channel interfaces
// Sample input, corrected result and configuration write channels.
// ---------------------------------------------------------------------------
interface fdcr_smp_if import fdcr_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic [CH_W-1:0]         channel;
	logic signed [SMP_W-1:0] sample_in;

	modport source (output valid, channel, sample_in, input ready);
	modport sink   (input valid, channel, sample_in, output ready);
endinterface

interface fdcr_res_if import fdcr_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic [CH_W-1:0]         out_channel;
	logic signed [SMP_W-1:0] sample_out;
	logic                    frame_end;

	modport source (output valid, out_channel, sample_out, frame_end, input ready);
	modport sink   (input valid, out_channel, sample_out, frame_end, output ready);
endinterface

interface fdcr_cfg_if import fdcr_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: rtl/framewise_dc_offset_remover.sv
`timescale 1ns / 1ps
`default_nettype none
`include "framewise_dc_offset_remover_defines.svh"
// ---------------------------------------------------------------------------
// framewise_dc_offset_remover: per-channel framewise DC offset removal
// Subtracts a linearly ramped DC estimate from each sample and renews the
// estimate from the frame mean at every frame close.
// ---------------------------------------------------------------------------
// One sample is in flight at a time. An ordinary sample passes through
// accept, state read-modify-write and result load; the sample that closes
// its channel's frame also waits while the mean, the leak and the new
// per-sample step each run in turn through the one shared multiplier.
// A finished result sits in an output register, so the next sample is taken
// while the previous result waits. Channel state (estimate, previous
// estimate, step, running offset, raw sum, frame position) lives in a
// single-port memory with one word per channel; per-entry valid bits make
// every channel read as zero after reset, so no clearing pass is needed.
// Samples on a channel at or above CHANNELS pass through unchanged.
// Configuration registers (index 0 frame_length, 1 inv_frame_length,
// 2 removal_rate) are written over the cfg channel; the user must write
// them only while no sample is in flight (the block does not enforce this);
// inv_frame_length must be set by software to match frame_length.
// ---------------------------------------------------------------------------
module framewise_dc_offset_remover import fdcr_pkg::*; #(
	parameter int CHANNELS  = CHANNELS_DEF,
	parameter int MAX_FRAME = MAX_FRAME_DEF
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	fdcr_smp_if.sink    samples,
	fdcr_res_if.source  results,
	fdcr_cfg_if.sink    cfg
);

	// --- derived sizes ---
	localparam int AW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int POS_W = $clog2(MAX_FRAME);
	localparam int LEN_W = ($clog2(MAX_FRAME + 1) > FL_W) ? $clog2(MAX_FRAME + 1) : FL_W;

	typedef struct packed {
		logic signed [Q_W-1:0]   est;
		logic signed [Q_W-1:0]   prev;
		logic signed [Q_W-1:0]   step;
		logic signed [Q_W-1:0]   ro;
		logic signed [SUM_W-1:0] sum;
		logic [POS_W-1:0]        pos;
	} chan_t;

	localparam int WORD_W = $bits(chan_t);

	// --- sequencer codes ---
	localparam logic [2:0] S_IDLE   = 3'd0;  // ready for a sample
	localparam logic [2:0] S_CALC   = 3'd1;  // state word arrived, correct sample
	localparam logic [2:0] S_MEAN   = 3'd2;  // waiting on sum * inv
	localparam logic [2:0] S_LEAK   = 3'd3;  // waiting on (mean - est) * rate
	localparam logic [2:0] S_STEPGO = 3'd4;  // launch step product
	localparam logic [2:0] S_STEP   = 3'd5;  // waiting on (est' - est) * inv
	localparam logic [2:0] S_WB     = 3'd6;  // write back renewed state
	localparam logic [2:0] S_EMIT   = 3'd7;  // hand result to output register

	logic [2:0] state_q;

	// --- configuration registers ---
	logic [FL_W-1:0]   frame_length_q;
	logic [INV_W-1:0]  inv_q;
	logic [RATE_W-1:0] rate_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_length_q <= FL_RESET;
			inv_q          <= INV_RESET;
			rate_q         <= RATE_RESET;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				CFG_FRAME_LENGTH:     frame_length_q <= cfg.data[FL_W-1:0];
				CFG_INV_FRAME_LENGTH: inv_q          <= cfg.data[INV_W-1:0];
				CFG_REMOVAL_RATE:     rate_q         <= cfg.data[RATE_W-1:0];
				default: ;  // unmapped index, dropped
			endcase
		end
	end

	// --- input transfer and channel decode ---
	logic                in_xfer;
	logic [CH_EXT_W-1:0] ch_ext;
	logic                ch_ok;

	assign samples.ready = (state_q == S_IDLE);
	assign in_xfer       = samples.valid && samples.ready;
	assign ch_ext        = CH_EXT_W'(samples.channel);
	assign ch_ok         = (ch_ext < CH_EXT_W'(CHANNELS));

	// held across the whole item
	logic [AW-1:0]           addr_q;
	logic signed [SMP_W-1:0] smp_q;
	logic signed [Q_W-1:0]   est_q;
	logic signed [Q_W-1:0]   est_new_q;
	logic signed [Q_W-1:0]   step_q;
	logic [CH_W-1:0]         res_ch_q;
	logic signed [SMP_W-1:0] res_smp_q;
	logic                    res_end_q;

	// --- state memory ---
	logic              mem_en;
	logic              mem_we;
	logic [AW-1:0]     mem_addr;
	chan_t             mem_wdata;
	logic [WORD_W-1:0] mem_rdata;
	chan_t             rd;

	// --- shared multiplier ---
	logic                      mul_start;
	logic signed [MUL_A_W-1:0] mul_a;
	logic [MUL_B_W-1:0]        mul_b;
	logic                      mul_done;
	logic signed [PROD_W-1:0]  mul_prod;

	fdcr_state_mem #(
		.DEPTH (CHANNELS),
		.AW    (AW),
		.WIDTH (WORD_W)
	) u_mem (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (mem_en),
		.we     (mem_we),
		.addr   (mem_addr),
		.wdata  (mem_wdata),
		.rdata  (mem_rdata)
	);

	fdcr_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.done   (mul_done),
		.prod   (mul_prod)
	);

	assign rd = chan_t'(mem_rdata);

	// --- sample correction on the fetched word ---
	logic signed [Q_W-1:0]     smp_q24;
	logic signed [Q_W+1:0]     diff_rnd;   // sample*2^24 - offset + half lsb
	logic signed [SMP_W-1:0]   smp_corr;
	logic signed [Q_W-1:0]     ro_inc;
	logic signed [SUM_W-1:0]   sum_new;
	logic [LEN_W-1:0]          fl_ext;
	logic [LEN_W-1:0]          len_eff;
	logic [LEN_W-1:0]          pos_inc;
	logic                      is_end;

	always_comb begin
		smp_q24  = $signed({smp_q, 24'h0});
		diff_rnd = (Q_W+2)'(smp_q24) - (Q_W+2)'(rd.ro) + (Q_W+2)'(42'sd8388608);
		smp_corr = sat16(diff_rnd[Q_W+1:24]);
		ro_inc   = sat40(ACC_W'(rd.ro) + ACC_W'(rd.step));
		sum_new  = rd.sum + SUM_W'(smp_q);  // wraps in 29 bits

		// effective frame length clamped to 1..MAX_FRAME
		fl_ext = LEN_W'(frame_length_q);
		if (fl_ext > LEN_W'(MAX_FRAME))
			len_eff = LEN_W'(MAX_FRAME);
		else if (fl_ext == '0)
			len_eff = LEN_W'(1);
		else
			len_eff = fl_ext;
		pos_inc = LEN_W'(rd.pos) + LEN_W'(1);
		is_end  = (pos_inc >= len_eff);
	end

	// --- frame-close arithmetic around the multiplier ---
	logic signed [Q_W-1:0]    mean;
	logic signed [PROD_W-1:0] leak_sh;
	logic signed [PROD_W-1:0] step_sh;
	logic signed [Q_W-1:0]    est_next;
	logic signed [Q_W-1:0]    step_next;
	logic signed [Q_W-1:0]    ro_close;

	always_comb begin
		mean      = sat40(ACC_W'(mul_prod));
		leak_sh   = mul_prod >>> 16;   // floor of Q0.16 product
		step_sh   = mul_prod >>> 24;   // floor of Q0.24 product
		est_next  = sat40(ACC_W'(est_q) + ACC_W'(leak_sh));
		step_next = sat40(ACC_W'(step_sh));
		ro_close  = sat40(ACC_W'(est_q) + ACC_W'(step_q));
	end

	// multiplier launches: mean, then leak, then step
	always_comb begin
		mul_start = 1'b0;
		mul_a     = MUL_A_W'(sum_new);
		mul_b     = inv_q;
		unique case (state_q)
			S_CALC: begin
				mul_start = is_end;
			end
			S_MEAN: begin
				mul_start = mul_done;
				mul_a     = MUL_A_W'(mean) - MUL_A_W'(est_q);
				mul_b     = MUL_B_W'(rate_q);
			end
			S_STEPGO: begin
				mul_start = 1'b1;
				mul_a     = MUL_A_W'(est_new_q) - MUL_A_W'(est_q);
			end
			default: ;
		endcase
	end

	// memory port: read on accept, write on ordinary sample or frame close
	always_comb begin
		mem_we    = 1'b0;
		mem_en    = 1'b0;
		mem_addr  = addr_q;
		mem_wdata = rd;
		unique case (state_q)
			S_IDLE: begin
				mem_en   = in_xfer && ch_ok;
				mem_addr = ch_ext[AW-1:0];
			end
			S_CALC: begin
				mem_en         = !is_end;
				mem_we         = !is_end;
				mem_wdata.ro   = ro_inc;
				mem_wdata.sum  = sum_new;
				mem_wdata.pos  = pos_inc[POS_W-1:0];
			end
			S_WB: begin
				mem_en         = 1'b1;
				mem_we         = 1'b1;
				mem_wdata.est  = est_new_q;
				mem_wdata.prev = est_q;
				mem_wdata.step = step_q;
				mem_wdata.ro   = ro_close;
				mem_wdata.sum  = '0;
				mem_wdata.pos  = '0;
			end
			default: ;
		endcase
	end

	// --- output register ---
	logic                    out_valid_q;
	logic [CH_W-1:0]         out_ch_q;
	logic signed [SMP_W-1:0] out_smp_q;
	logic                    out_end_q;
	logic                    out_free;
	logic                    out_load;

	assign out_free = !out_valid_q || results.ready;
	assign out_load = (state_q == S_EMIT) && out_free;

	assign results.valid       = out_valid_q;
	assign results.out_channel = out_ch_q;
	assign results.sample_out  = out_smp_q;
	assign results.frame_end   = out_end_q;

	// --- sequencer ---
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load)
				out_valid_q <= 1'b1;
			else if (results.ready)
				out_valid_q <= 1'b0;

			unique case (state_q)
				S_IDLE: begin
					if (in_xfer) state_q <= ch_ok ? S_CALC : S_EMIT;
				end
				S_CALC: begin
					state_q <= is_end ? S_MEAN : S_EMIT;
				end
				S_MEAN: begin
					if (mul_done) state_q <= S_LEAK;
				end
				S_LEAK: begin
					if (mul_done) state_q <= S_STEPGO;
				end
				S_STEPGO: begin
					state_q <= S_STEP;
				end
				S_STEP: begin
					if (mul_done) state_q <= S_WB;
				end
				S_WB: begin
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (out_free) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// item working registers
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			addr_q    <= ch_ext[AW-1:0];
			smp_q     <= samples.sample_in;
			res_ch_q  <= samples.channel;
			res_smp_q <= samples.sample_in;   // pass-through for unused channels
			res_end_q <= 1'b0;
		end
		if (state_q == S_CALC) begin
			res_smp_q <= smp_corr;
			res_end_q <= is_end;
			est_q     <= rd.est;
		end
		if (state_q == S_LEAK && mul_done) est_new_q <= est_next;
		if (state_q == S_STEP && mul_done) step_q    <= step_next;
		if (out_load) begin
			out_ch_q  <= res_ch_q;
			out_smp_q <= res_smp_q;
			out_end_q <= res_end_q;
		end
	end

	// --- checks ---
	logic mul_waiting;

	assign mul_waiting = (state_q == S_MEAN) || (state_q == S_LEAK) || (state_q == S_STEP);

	`FDCR_ASSERT_IMPL(a_calc_after_xfer, clk, arst_n, state_q == S_CALC, $past(in_xfer))
	`FDCR_ASSERT_IMPL(a_mul_done_waited, clk, arst_n, mul_done, mul_waiting)
	`FDCR_ASSERT_NEXT(a_xfer_next_state, clk, arst_n, in_xfer, state_q == S_CALC || state_q == S_EMIT)
	`FDCR_ASSERT_IMPL(a_out_from_emit, clk, arst_n, $rose(results.valid), $past(state_q) == S_EMIT)

endmodule

`default_nettype wire

// File: rtl/fdcr_state_mem.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// fdcr_state_mem: per-channel state memory
// Single port, registered read; entries never written read back as zero.
// ---------------------------------------------------------------------------
module fdcr_state_mem import fdcr_pkg::*; #(
	parameter int DEPTH = CHANNELS_DEF,
	parameter int AW    = 3,
	parameter int WIDTH = 8
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             en,
	input  wire logic             we,
	input  wire logic [AW-1:0]    addr,
	input  wire logic [WIDTH-1:0] wdata,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [DEPTH-1:0] valid_q;
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (en && we) begin
			valid_q[addr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (en && we) begin
			mem[addr] <= wdata;
		end
		if (en && !we) begin
			rdata_q <= valid_q[addr] ? mem[addr] : '0;
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// File: rtl/fdcr_mul.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// fdcr_mul: shared sequential multiplier
// Signed 41 x unsigned 24 product from two 25x25 halves; low, high, sum, then done.
// ---------------------------------------------------------------------------
module fdcr_mul import fdcr_pkg::*; (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      start,
	input  wire logic signed [MUL_A_W-1:0] a,
	input  wire logic [MUL_B_W-1:0]        b,
	output logic                           done,
	output logic signed [PROD_W-1:0]       prod
);

	localparam logic [1:0] M_IDLE = 2'd0;
	localparam logic [1:0] M_LO   = 2'd1;
	localparam logic [1:0] M_HI   = 2'd2;
	localparam logic [1:0] M_SUM  = 2'd3;

	localparam int OP_W = MUL_B_W + 1;

	logic [1:0]                   mstate_q;
	logic                         done_q;
	logic signed [MUL_A_W-1:0]    a_q;
	logic [MUL_B_W-1:0]           b_q;
	logic [2*MUL_LO_W-1:0]        lo_q;
	logic signed [MUL_A_W:0]      hi_q;
	logic signed [PROD_W-1:0]     prod_q;

	logic signed [OP_W-1:0]       x;
	logic signed [OP_W-1:0]       y;
	logic signed [2*OP_W-1:0]     m;
	logic signed [ACC_W-1:0]      acc;

	// one multiplier, low half first (unsigned), then signed high half
	always_comb begin
		if (mstate_q == M_LO)
			x = $signed({1'b0, a_q[MUL_LO_W-1:0]});
		else
			x = OP_W'($signed(a_q[MUL_A_W-1:MUL_LO_W]));
		y   = $signed({1'b0, b_q});
		m   = x * y;
		acc = (ACC_W'(hi_q) <<< MUL_LO_W) +
			$signed({{(ACC_W-2*MUL_LO_W){1'b0}}, lo_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mstate_q <= M_IDLE;
			done_q   <= 1'b0;
		end else begin
			done_q <= (mstate_q == M_SUM);
			unique case (mstate_q)
				M_IDLE: if (start) mstate_q <= M_LO;
				M_LO:   mstate_q <= M_HI;
				M_HI:   mstate_q <= M_SUM;
				M_SUM:  mstate_q <= M_IDLE;
				default: mstate_q <= M_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= a;
			b_q <= b;
		end
		if (mstate_q == M_LO) lo_q <= m[2*MUL_LO_W-1:0];
		if (mstate_q == M_HI) hi_q <= m[MUL_A_W:0];
		if (mstate_q == M_SUM) prod_q <= acc[PROD_W-1:0];
	end

	assign done = done_q;
	assign prod = prod_q;

endmodule

`default_nettype wire

// File: dv/fdcr_result_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fdcr_result_checker: offset removal predictor and result comparator
// Watches the sample, result and register channels, computes the corrected
// sample for every accepted transfer and compares results in arrival order.
// ---------------------------------------------------------------------------
module fdcr_result_checker import fdcr_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	fdcr_smp_if  smp,
	fdcr_res_if  res,
	fdcr_cfg_if  cfg,
	output int   mismatches,
	output int   pending,
	output int   checked,
	output int   closes
);

	// wide enough that no product or sum below can overflow
	typedef logic signed [127:0] wide_t;

	typedef struct packed {
		logic [CH_W-1:0]         ch;
		logic signed [SMP_W-1:0] smp;
		logic                    closed;
	} corrected_t;

	localparam int NCH = CHANNELS_DEF;

	corrected_t corrected_q[$];

	// per-channel state, Q16.24
	logic signed [Q_W-1:0]   dc_est      [NCH];
	logic signed [Q_W-1:0]   dc_prev     [NCH];
	logic signed [Q_W-1:0]   ramp_step   [NCH];
	logic signed [Q_W-1:0]   ramp_offset [NCH];
	logic signed [SUM_W-1:0] frame_sum   [NCH];
	int unsigned             frame_pos   [NCH];

	logic [FL_W-1:0]   frame_len;
	logic [INV_W-1:0]  inv_len;
	logic [RATE_W-1:0] leak_rate;

	function automatic logic signed [Q_W-1:0] clip40(input wide_t v);
		wide_t hi;
		wide_t lo;
		hi = Q_MAX;
		lo = Q_MIN;
		if (v > hi)
			return Q_MAX;
		if (v < lo)
			return Q_MIN;
		return v[Q_W-1:0];
	endfunction

	// corrected sample for one input; updates the channel state as it goes
	function automatic corrected_t correct_sample(input logic [CH_W-1:0] ch,
			input logic signed [SMP_W-1:0] x);
		corrected_t  r;
		wide_t       xw;
		wide_t       diff;
		wide_t       o;
		wide_t       sum_w;
		wide_t       mean;
		wide_t       old;
		wide_t       lk;
		wide_t       inv_w;
		wide_t       rate_w;
		int unsigned len;
		xw = x;
		inv_w = inv_len;
		rate_w = leak_rate;
		r.ch = ch;
		r.closed = 1'b0;

		// round half up, then clamp to 16 bits
		diff = (xw <<< 24) - wide_t'(ramp_offset[ch]);
		o = (diff + (wide_t'(1) <<< 23)) >>> 24;
		if (o > 32767)
			r.smp = 16'sh7fff;
		else if (o < -32768)
			r.smp = 16'sh8000;
		else
			r.smp = o[SMP_W-1:0];

		ramp_offset[ch] = clip40(wide_t'(ramp_offset[ch]) + wide_t'(ramp_step[ch]));
		frame_sum[ch] = frame_sum[ch] + x;   // wraps in 29 bits

		len = frame_len;
		if (len > MAX_FRAME_DEF)
			len = MAX_FRAME_DEF;
		if (len < 1)
			len = 1;

		if (frame_pos[ch] + 1 >= len) begin
			sum_w = frame_sum[ch];
			mean = clip40(sum_w * inv_w);
			old = dc_est[ch];
			lk = ((mean - old) * rate_w) >>> 16;
			dc_est[ch] = clip40(old + lk);
			dc_prev[ch] = old[Q_W-1:0];
			ramp_step[ch] = clip40(((wide_t'(dc_est[ch]) - old) * inv_w) >>> 24);
			ramp_offset[ch] = clip40(wide_t'(dc_prev[ch]) + wide_t'(ramp_step[ch]));
			frame_sum[ch] = '0;
			frame_pos[ch] = 0;
			r.closed = 1'b1;
		end else begin
			frame_pos[ch] = (frame_pos[ch] + 1) & 32'h1fff;
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		corrected_t got;
		corrected_t want;
		if (!arst_n) begin
			for (int c = 0; c < NCH; c++) begin
				dc_est[c] = '0;
				dc_prev[c] = '0;
				ramp_step[c] = '0;
				ramp_offset[c] = '0;
				frame_sum[c] = '0;
				frame_pos[c] = 0;
			end
			frame_len = FL_RESET;
			inv_len = INV_RESET;
			leak_rate = RATE_RESET;
			corrected_q.delete();
			mismatches = 0;
			pending = 0;
			checked = 0;
			closes = 0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					CFG_FRAME_LENGTH:     frame_len = cfg.data[FL_W-1:0];
					CFG_INV_FRAME_LENGTH: inv_len = cfg.data[INV_W-1:0];
					CFG_REMOVAL_RATE:     leak_rate = cfg.data[RATE_W-1:0];
					default: ;
				endcase
			end

			if (smp.valid && smp.ready)
				corrected_q.push_back(correct_sample(smp.channel, smp.sample_in));

			if (res.valid && res.ready) begin
				got.ch = res.out_channel;
				got.smp = res.sample_out;
				got.closed = res.frame_end;
				checked++;
				if (got.closed)
					closes++;
				if (corrected_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%t: unexpected result ch %0d sample %0d end %0b",
							$realtime, got.ch, got.smp, got.closed);
				end else begin
					want = corrected_q.pop_front();
					if (got.ch !== want.ch || got.smp !== want.smp
							|| got.closed !== want.closed) begin
						mismatches++;
						if (mismatches <= 10)
							$display("%t: mismatch: expected ch %0d sample %0d end %0b,",
								$realtime, want.ch, want.smp, want.closed,
								" got ch %0d sample %0d end %0b",
								got.ch, got.smp, got.closed);
					end
				end
			end
			pending = corrected_q.size();
		end
	end

endmodule

// File: dv/framewise_dc_offset_remover_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// framewise_dc_offset_remover_tb: stimulus and verdict for the DC remover
// Drives samples and register writes, throttles the result side, and lets
// the checker predict and compare every corrected sample.
// ---------------------------------------------------------------------------
module framewise_dc_offset_remover_tb import fdcr_pkg::*; ();

	logic clk;
	logic arst_n;

	fdcr_smp_if smp_ch();
	fdcr_res_if res_ch();
	fdcr_cfg_if cfg_ch();

	framewise_dc_offset_remover dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.samples (smp_ch),
		.results (res_ch),
		.cfg     (cfg_ch)
	);

	int mismatches;
	int pending;
	int checked;
	int closes;

	fdcr_result_checker chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.smp        (smp_ch),
		.res        (res_ch),
		.cfg        (cfg_ch),
		.mismatches (mismatches),
		.pending    (pending),
		.checked    (checked),
		.closes     (closes)
	);

	localparam int LONG_HOLD = 300;   // cycles the result side refuses transfers

	// idle odds, percent of cycles; set per phase by the stimulus
	int src_idle = 31;
	int snk_idle = 73;

	// long hold-off on the result side, owned by its own process
	logic hold_request = 1'b0;
	logic hold_active = 1'b0;

	int samples_sent = 0;
	int settings_done = 0;

	// per-phase stimulus shaping: a DC bias per channel and two busy channels
	int              bias [CHANNELS_DEF];
	logic [CH_W-1:0] hot0;
	logic [CH_W-1:0] hot1;

	// 4 ns clock
	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	// run limit, far beyond the slowest legal run
	initial begin
		#2_000_000;
		$display("== FAIL ==");
		$finish;
	end

	// result side: random back-pressure, or a solid stall while held off
	initial begin
		res_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			res_ch.ready <= !hold_active && ($urandom_range(99) >= snk_idle);
		end
	end

	initial begin
		wait (hold_request);
		@(negedge clk);
		hold_active <= 1'b1;
		repeat (LONG_HOLD) @(negedge clk);
		hold_active <= 1'b0;
	end

	// One sample transfer. Called at a falling edge; returns at a falling edge
	// with valid still high, so back-to-back samples keep valid asserted.
	task automatic send_sample(input logic [CH_W-1:0] ch, input logic signed [SMP_W-1:0] v);
		while ($urandom_range(99) < src_idle) begin
			smp_ch.valid <= 1'b0;
			@(negedge clk);
		end
		smp_ch.valid <= 1'b1;
		smp_ch.channel <= ch;
		smp_ch.sample_in <= v;
		@(posedge clk);
		while (!smp_ch.ready)
			@(posedge clk);
		@(negedge clk);
		samples_sent++;
	endtask

	// stop offering samples and wait for every expected result to arrive
	task automatic drain();
		smp_ch.valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= val;
		@(posedge clk);
		while (!cfg_ch.ready)
			@(posedge clk);
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
		@(negedge clk);
	endtask

	// Registers only change with the block idle. The unused upper data bits
	// get random junk so that every data bit toggles.
	task automatic apply_setting(input int fl, input logic [INV_W-1:0] inv,
			input logic [RATE_W-1:0] rate);
		drain();
		write_reg(CFG_FRAME_LENGTH, {11'($urandom), 13'(fl)});
		write_reg(CFG_INV_FRAME_LENGTH, inv);
		write_reg(CFG_REMOVAL_RATE, {8'($urandom), rate});
		settings_done++;
	endtask

	// Mix of full-range noise, field extremes and a biased signal that gives
	// the estimate something to converge on.
	function automatic logic signed [SMP_W-1:0] pick_sample(input logic [CH_W-1:0] ch);
		int mode;
		int t;
		mode = $urandom_range(9);
		if (mode < 4)
			return 16'($urandom);
		if (mode < 6) begin
			case ($urandom_range(3))
				0: return 16'sh7fff;
				1: return 16'sh8000;
				2: return 16'sh0000;
				default: return 16'shffff;
			endcase
		end
		t = bias[ch] + int'($urandom_range(512)) - 256;
		if (t > 32767)
			t = 32767;
		if (t < -32768)
			t = -32768;
		return 16'(t);
	endfunction

	initial begin
		int              fl;
		int              n;
		logic [INV_W-1:0]  inv;
		logic [RATE_W-1:0] rate;
		logic [CH_W-1:0]   ch;

		smp_ch.valid = 1'b0;
		smp_ch.channel = '0;
		smp_ch.sample_in = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = CFG_FRAME_LENGTH;
		cfg_ch.data = '0;
		arst_n = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// ---- directed part ----
		// two-sample frames, full leak: estimate jumps to the frame mean
		apply_setting(2, 24'd8388608, 16'd65535);
		send_sample(3'd0, 16'sh7fff);
		send_sample(3'd0, 16'sh7fff);
		// offset now pushes a negative full-scale sample past the low rail
		send_sample(3'd0, 16'sh8000);
		send_sample(3'd0, 16'sh8000);
		send_sample(3'd7, 16'sh8000);
		send_sample(3'd7, 16'sh7fff);
		send_sample(3'd0, 16'sh7fff);
		send_sample(3'd0, 16'sh7fff);

		// length zero acts as one: every sample closes its frame
		apply_setting(0, 24'hffffff, 16'd65535);
		send_sample(3'd1, 16'sd12345);
		send_sample(3'd1, -16'sd1);
		send_sample(3'd1, 16'sd0);

		// length one, smallest reciprocal
		apply_setting(1, 24'd4096, 16'd65535);
		send_sample(3'd2, 16'sh8000);
		send_sample(3'd2, 16'sh7fff);

		// length lowered below the position mid-frame: next sample closes
		apply_setting(8, 24'd2097152, 16'd32768);
		repeat (5) send_sample(3'd3, 16'sd1000);
		apply_setting(2, 24'd8388608, 16'd32768);
		send_sample(3'd3, 16'sd500);

		// ---- random part ----
		// Twelve register settings. Idling: sender light / receiver heavy for
		// the first four, the reverse for the next four, none for the last.
		for (int p = 0; p < 12; p++) begin
			case (p)
				0:  begin fl = 4;    inv = 24'd4194304;  rate = 16'd65535; n = 150; end
				1:  begin fl = 16;   inv = 24'd1048576;  rate = 16'd655;   n = 150; end
				2:  begin fl = 3;    inv = 24'd5592405;  rate = 16'd32768; n = 150; end
				3:  begin fl = 2;    inv = 24'd8388608;  rate = 16'd0;     n = 140; end
				// reciprocal far too large: the mean saturates
				4:  begin fl = 8;    inv = 24'hffffff;   rate = 16'd65535; n = 150; end
				5:  begin fl = 0;    inv = 24'd4096;     rate = 16'd40000; n = 140; end
				6:  begin
					fl = 2 * $urandom_range(1, 16);
					inv = 24'(16777216 / fl);
					rate = 16'($urandom);
					n = 150;
				end
				// beyond the maximum: clamped to 4096, frames stay open
				7:  begin fl = 8191; inv = 24'd4096;     rate = 16'd65535; n = 60;  end
				8:  begin fl = 4096; inv = 24'd4096;     rate = 16'd655;   n = 60;  end
				// long positions left behind close on the next sample
				9:  begin fl = 6;    inv = 24'd2796202;  rate = 16'd65535; n = 150; end
				10: begin
					fl = $urandom_range(1, 40);
					inv = 24'(4096 + $urandom_range(16777215 - 4096));
					rate = 16'($urandom);
					n = 200;
				end
				default: begin fl = 12; inv = 24'd1398101; rate = 16'd1; n = 200; end
			endcase

			case (p / 4)
				0:       begin src_idle = 31; snk_idle = 73; end
				1:       begin src_idle = 73; snk_idle = 31; end
				default: begin src_idle = 0;  snk_idle = 0;  end
			endcase

			for (int c = 0; c < CHANNELS_DEF; c++)
				bias[c] = int'($urandom_range(60000)) - 30000;
			hot0 = 3'($urandom_range(7));
			hot1 = 3'($urandom_range(7));

			apply_setting(fl, inv, rate);
			for (int i = 0; i < n; i++) begin
				// result side stalls for a long stretch while samples keep coming
				if (p == 0 && i == 40)
					hold_request = 1'b1;
				// sender waits out every outstanding result once mid-phase
				if (p == 4 && i == n / 2)
					drain();
				if ($urandom_range(1))
					ch = $urandom_range(1) ? hot0 : hot1;
				else
					ch = 3'($urandom_range(7));
				send_sample(ch, pick_sample(ch));
			end
		end

		drain();
		repeat (20) @(negedge clk);

		$display("Run covered %0d samples under %0d register settings.",
			samples_sent, settings_done);
		$display("Checked %0d corrected samples, %0d of them closing a frame.",
			checked, closes);
		if (mismatches == 0 && pending == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

// File: framewise_dc_offset_remover.f
+incdir+rtl
rtl/fdcr_pkg.sv
rtl/fdcr_ifs.sv
rtl/fdcr_state_mem.sv
rtl/fdcr_mul.sv
rtl/framewise_dc_offset_remover.sv
dv/fdcr_result_checker.sv
dv/framewise_dc_offset_remover_tb.sv
